@@ hw/rtl/ppwf_pkg.sv @@
// shared types and constants for the peak position and width finder
`default_nettype none

package ppwf_pkg;

	localparam int SAMPLE_W = 24;
	localparam int POS_W    = 11;
	localparam int WIDTH_W  = 10;
	localparam int QUAL_W   = SAMPLE_W + 3;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic load;
		logic rd_en;
		logic left_init;
		logic left_edge;
		logic left_step;
		logic left_done;
		logic right_init;
		logic right_edge;
		logic right_step;
		logic right_done;
		logic result_load;
	} cmd_t;

	typedef struct packed {
		logic pos_gt1;
		logic pos_lt_len;
		logic p_gt1;
		logic p_lt_len;
		logic qual;
	} sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/ppwf_in_if.sv @@
// sample input channel
`default_nettype none

interface ppwf_in_if
	import ppwf_pkg::*;
;
	logic    valid;
	logic    ready;
	sample_t sample;
	logic    last;

	modport source (output valid, output sample, output last, input ready);
	modport sink (input valid, input sample, input last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ppwf_out_if.sv @@
// result output channel
`default_nettype none

interface ppwf_out_if
	import ppwf_pkg::*;
;
	logic               valid;
	logic               ready;
	sample_t            peak_value;
	logic [POS_W-1:0]   peak_position;
	logic [WIDTH_W-1:0] width;
	logic               overflow;

	modport source (output valid, output peak_value, output peak_position, output width,
		output overflow, input ready);
	modport sink (input valid, input peak_value, input peak_position, input width,
		input overflow, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/peak_position_and_width_finder.sv @@
// Peak position and width finder. Samples of a profile are taken one per cycle into
// an internal store of MAX_SAMPLES entries while the running maximum and the position
// of its first occurrence are tracked; samples past capacity are dropped and flagged.
// The transfer that carries last starts the width search; from then until the result
// is loaded no sample is taken. Each side is set up first, then every stored sample
// examined gets a store read followed by its threshold compare with the pointer step;
// a scan that runs to the profile end stops on a bound test. The result register is
// loaded once both scans end, and the load is held off while an earlier result still
// waits to be taken. The result register lets the next profile load while an earlier
// result still waits to be taken. No clearing pass is needed after reset.
`default_nettype none

module peak_position_and_width_finder
	import ppwf_pkg::*;
#(
	parameter int MAX_SAMPLES = 1024
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ppwf_in_if.sink   samples,
	ppwf_out_if.source results
);

	cmd_t cmd;
	sts_t sts;

	ppwf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_last   (samples.last),
		.in_ready  (samples.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ppwf_dp #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.sample        (samples.sample),
		.peak_value    (results.peak_value),
		.peak_position (results.peak_position),
		.width         (results.width),
		.overflow      (results.overflow)
	);

	// every store read is followed by a scan decision
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |=> (cmd.left_done || cmd.left_step || cmd.right_done || cmd.right_step))
		else $error("store read not followed by a scan decision");

	// a pending result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.result_load |-> !(results.valid && !results.ready))
		else $error("result register overwritten while occupied");

	// no sample transfer while the store is being scanned
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> !samples.ready)
		else $error("input ready during scan");

	// a transfer with last starts the scan on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(samples.valid && samples.ready && samples.last) |=> !samples.ready)
		else $error("input still ready after last transfer");

endmodule

`default_nettype wire

@@ hw/rtl/ppwf_ram.sv @@
// generic single write port ram with registered read
`default_nettype none

module ppwf_ram #(
	parameter int WIDTH  = 24,
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/ppwf_ctrl.sv @@
// controller state machine: load, left scan, right scan, result hand-off
`default_nettype none

module ppwf_ctrl
	import ppwf_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic in_last,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	localparam logic [3:0] ST_LOAD   = 4'd0;
	localparam logic [3:0] ST_L_INIT = 4'd1;
	localparam logic [3:0] ST_L_TEST = 4'd2;
	localparam logic [3:0] ST_L_CHK  = 4'd3;
	localparam logic [3:0] ST_R_INIT = 4'd4;
	localparam logic [3:0] ST_R_TEST = 4'd5;
	localparam logic [3:0] ST_R_CHK  = 4'd6;
	localparam logic [3:0] ST_FIN    = 4'd7;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = (state_q == ST_LOAD);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_LOAD: begin
				cmd.load = in_valid;
				if (in_valid && in_last) begin
					state_d = ST_L_INIT;
				end
			end
			ST_L_INIT: begin
				if (sts.pos_gt1) begin
					cmd.left_init = 1'b1;
					state_d       = ST_L_TEST;
				end else begin
					cmd.left_edge = 1'b1;
					state_d       = ST_R_INIT;
				end
			end
			ST_L_TEST: begin
				if (sts.p_gt1) begin
					cmd.rd_en = 1'b1;
					state_d   = ST_L_CHK;
				end else begin
					cmd.left_done = 1'b1;
					state_d       = ST_R_INIT;
				end
			end
			ST_L_CHK: begin
				if (sts.qual) begin
					cmd.left_done = 1'b1;
					state_d       = ST_R_INIT;
				end else begin
					cmd.left_step = 1'b1;
					state_d       = ST_L_TEST;
				end
			end
			ST_R_INIT: begin
				if (sts.pos_lt_len) begin
					cmd.right_init = 1'b1;
					state_d        = ST_R_TEST;
				end else begin
					cmd.right_edge = 1'b1;
					state_d        = ST_FIN;
				end
			end
			ST_R_TEST: begin
				if (sts.p_lt_len) begin
					cmd.rd_en = 1'b1;
					state_d   = ST_R_CHK;
				end else begin
					cmd.right_done = 1'b1;
					state_d        = ST_FIN;
				end
			end
			ST_R_CHK: begin
				if (sts.qual) begin
					cmd.right_done = 1'b1;
					state_d        = ST_FIN;
				end else begin
					cmd.right_step = 1'b1;
					state_d        = ST_R_TEST;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.result_load = 1'b1;
					state_d         = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.result_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/ppwf_dp.sv @@
// datapath: sample store, running peak, scan pointer, threshold test, result register
`default_nettype none

module ppwf_dp
	import ppwf_pkg::*;
#(
	parameter int MAX_SAMPLES = 1024
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire cmd_t     cmd,
	output sts_t          sts,
	input  wire sample_t  sample,
	output sample_t       peak_value,
	output logic [POS_W-1:0]   peak_position,
	output logic [WIDTH_W-1:0] width,
	output logic          overflow
);

	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

	logic [CW-1:0] count_q;
	sample_t       max_q;
	logic [CW-1:0] pos_q;
	logic          drop_q;
	logic [CW-1:0] p_q;
	logic [CW-1:0] left_q;
	logic [CW-1:0] right_q;

	sample_t            peak_value_q;
	logic [POS_W-1:0]   peak_position_q;
	logic [WIDTH_W-1:0] width_q;
	logic               overflow_q;

	logic          full;
	logic          wr_en;
	logic [CW-1:0] rd_idx;
	sample_t       rdata;
	logic          zpos;
	logic          edge_ext;
	logic [CW-1:0] w;
	logic [CW+POS_W-1:0]   pos_ext;
	logic [CW+WIDTH_W-1:0] w_ext;
	logic signed [QUAL_W-1:0] s_x;
	logic signed [QUAL_W-1:0] z_x;
	logic signed [QUAL_W-1:0] lhs;
	logic signed [QUAL_W-1:0] rhs;

	assign full     = (count_q == CW'(MAX_SAMPLES));
	assign wr_en    = cmd.load && !full;
	assign rd_idx   = p_q - CW'(1);
	assign zpos     = !max_q[SAMPLE_W-1] && (max_q != '0);
	assign edge_ext = zpos;

	ppwf_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_SAMPLES)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[AW-1:0]),
		.wdata (sample),
		.re    (cmd.rd_en),
		.raddr (rd_idx[AW-1:0]),
		.rdata (rdata)
	);

	// 5*s against zmax (positive peak) or 6*zmax
	assign s_x = QUAL_W'(rdata);
	assign z_x = QUAL_W'(max_q);
	assign lhs = (s_x <<< 2) + s_x;
	assign rhs = zpos ? z_x : ((z_x <<< 2) + (z_x <<< 1));

	assign sts.qual       = (lhs <= rhs);
	assign sts.pos_gt1    = (pos_q > CW'(1));
	assign sts.pos_lt_len = (pos_q < count_q);
	assign sts.p_gt1      = (p_q > CW'(1));
	assign sts.p_lt_len   = (p_q < count_q);

	assign w       = ((left_q == '0) || (right_q == '0)) ? '0 :
		((left_q > right_q) ? left_q : right_q);
	assign pos_ext = {{POS_W{1'b0}}, pos_q};
	assign w_ext   = {{WIDTH_W{1'b0}}, w};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			max_q   <= '0;
			pos_q   <= '0;
			drop_q  <= 1'b0;
		end else if (cmd.load) begin
			if (!full) begin
				count_q <= count_q + CW'(1);
				if ((count_q == '0) || (sample > max_q)) begin
					max_q <= sample;
					pos_q <= count_q + CW'(1);
				end
			end else begin
				drop_q <= 1'b1;
			end
		end else if (cmd.result_load) begin
			count_q <= '0;
			max_q   <= '0;
			pos_q   <= '0;
			drop_q  <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.left_init) begin
			p_q <= pos_q - CW'(1);
		end else if (cmd.left_step) begin
			p_q <= p_q - CW'(1);
		end else if (cmd.right_init) begin
			p_q <= pos_q + CW'(1);
		end else if (cmd.right_step) begin
			p_q <= p_q + CW'(1);
		end

		if (cmd.left_edge) begin
			left_q <= CW'(edge_ext);
		end else if (cmd.left_done) begin
			left_q <= pos_q - p_q;
		end

		if (cmd.right_edge) begin
			right_q <= CW'(edge_ext);
		end else if (cmd.right_done) begin
			right_q <= p_q - pos_q;
		end

		if (cmd.result_load) begin
			peak_value_q    <= max_q;
			peak_position_q <= pos_ext[POS_W-1:0];
			width_q         <= w_ext[WIDTH_W-1:0];
			overflow_q      <= drop_q;
		end
	end

	assign peak_value    = peak_value_q;
	assign peak_position = peak_position_q;
	assign width         = width_q;
	assign overflow      = overflow_q;

endmodule

`default_nettype wire

@@ bench/tb_peak_position_and_width_finder.sv @@
// self-checking testbench for the peak position and width finder
`default_nettype none

module tb_peak_position_and_width_finder;
	import ppwf_pkg::*;

	localparam int PROFILE_DEPTH = 1024;
	localparam int RANDOM_ITEMS  = 800;
	localparam int HOLD_CYCLES   = 2500;
	localparam int CYCLE_LIMIT   = 400000;

	typedef struct {
		sample_t sample;
		logic    last;
		bit      drain_first;
	} sample_item_t;

	typedef struct packed {
		sample_t            peak_value;
		logic [POS_W-1:0]   peak_position;
		logic [WIDTH_W-1:0] width;
		logic               overflow;
	} peak_result_t;

	logic clk;
	logic arst_n;

	ppwf_in_if  samples_ch ();
	ppwf_out_if results_ch ();

	peak_position_and_width_finder #(
		.MAX_SAMPLES(PROFILE_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples_ch),
		.results(results_ch)
	);

	sample_item_t pending_samples[$];
	peak_result_t expected_peaks[$];

	sample_t profile_store[PROFILE_DEPTH];
	int      stored_count;
	sample_t top_value;
	int      top_pos;
	bit      overflowed;

	int cycle_count;
	int error_count;
	int results_seen;
	int hold_left;
	bit hold_started;
	bit quiet_window;

	assign quiet_window = (cycle_count % 6000) < 1500;

	function automatic bit meets_floor(sample_t s, sample_t peak);
		longint lhs;
		lhs = longint'(s) * 5;
		if (peak > 0)
			return lhs <= longint'(peak);
		return lhs <= longint'(peak) * 6;
	endfunction

	// running max on load, width search on the final sample
	task automatic absorb_sample(input sample_t s, input logic is_last);
		int k;
		int left_ext;
		int right_ext;
		int span;
		peak_result_t r;
		if (stored_count < PROFILE_DEPTH) begin
			profile_store[stored_count] = s;
			stored_count++;
			if (stored_count == 1 || s > top_value) begin
				top_value = s;
				top_pos = stored_count;
			end
		end else begin
			overflowed = 1'b1;
		end
		if (is_last) begin
			if (top_pos > 1) begin
				k = top_pos - 1;
				while (k > 1 && !meets_floor(profile_store[k-1], top_value))
					k--;
				left_ext = top_pos - k;
			end else begin
				left_ext = (top_value > 0) ? 1 : 0;
			end
			if (top_pos < stored_count) begin
				k = top_pos + 1;
				while (k < stored_count && !meets_floor(profile_store[k-1], top_value))
					k++;
				right_ext = k - top_pos;
			end else begin
				right_ext = (top_value > 0) ? 1 : 0;
			end
			if (left_ext == 0 || right_ext == 0)
				span = 0;
			else
				span = (left_ext > right_ext) ? left_ext : right_ext;
			r.peak_value = top_value;
			r.peak_position = POS_W'(top_pos);
			r.width = WIDTH_W'(span);
			r.overflow = overflowed;
			expected_peaks.push_back(r);
			stored_count = 0;
			top_value = '0;
			top_pos = 0;
			overflowed = 1'b0;
		end
	endtask

	function automatic sample_t draw_sample(int shape, int amp);
		case (shape)
			0: return sample_t'($urandom());
			1: return sample_t'(int'($urandom_range(0, 40)) - 20);
			2: return sample_t'(-int'($urandom_range(1, 5000)));
			default: begin
				if ($urandom_range(0, 7) == 0)
					return sample_t'($urandom_range(0, amp / 5));
				return sample_t'($urandom_range(amp / 3, amp));
			end
		endcase
	endfunction

	task automatic push_sample(input int v, input bit is_last, input bit drain);
		sample_item_t it;
		it.sample = sample_t'(v);
		it.last = is_last;
		it.drain_first = drain;
		pending_samples.push_back(it);
	endtask

	task automatic queue_profile(input int len, input int shape, input bit drain);
		int amp;
		amp = $urandom_range(1, 8000000);
		for (int i = 0; i < len; i++)
			push_sample(draw_sample(shape, amp), i == len - 1, drain && i == 0);
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL peak_position_and_width_finder");
			$finish;
		end
	end

	// sender
	always @(posedge clk) begin
		if (arst_n && (!samples_ch.valid || samples_ch.ready)) begin
			if (pending_samples.size() != 0
				&& !(pending_samples[0].drain_first
					&& (samples_ch.valid || expected_peaks.size() != 0))
				&& (quiet_window || $urandom_range(0, 99) >= 35)) begin
				samples_ch.valid <= 1'b1;
				samples_ch.sample <= pending_samples[0].sample;
				samples_ch.last <= pending_samples[0].last;
				void'(pending_samples.pop_front());
			end else begin
				samples_ch.valid <= 1'b0;
			end
		end
	end

	// receiver, with one long hold-off so the block backs up
	always @(posedge clk) begin
		if (!arst_n) begin
			results_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			results_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_started && results_seen >= 12) begin
			hold_started <= 1'b1;
			hold_left <= HOLD_CYCLES;
			results_ch.ready <= 1'b0;
		end else begin
			results_ch.ready <= quiet_window || $urandom_range(0, 99) >= 35;
		end
	end

	always @(posedge clk) begin : watch
		peak_result_t want;
		if (arst_n) begin
			if (samples_ch.valid && samples_ch.ready)
				absorb_sample(samples_ch.sample, samples_ch.last);
			if (results_ch.valid && results_ch.ready) begin
				results_seen++;
				if (expected_peaks.size() == 0) begin
					$error("result with no profile pending: peak_value %0d position %0d",
						results_ch.peak_value, results_ch.peak_position);
					error_count++;
				end else begin
					want = expected_peaks.pop_front();
					if (results_ch.peak_value !== want.peak_value) begin
						$error("peak_value: expected %0d, got %0d",
							want.peak_value, results_ch.peak_value);
						error_count++;
					end
					if (results_ch.peak_position !== want.peak_position) begin
						$error("peak_position: expected %0d, got %0d",
							want.peak_position, results_ch.peak_position);
						error_count++;
					end
					if (results_ch.width !== want.width) begin
						$error("width: expected %0d, got %0d", want.width, results_ch.width);
						error_count++;
					end
					if (results_ch.overflow !== want.overflow) begin
						$error("overflow: expected %0d, got %0d",
							want.overflow, results_ch.overflow);
						error_count++;
					end
				end
			end
		end
	end

	initial begin
		int random_count;
		int len;
		bit first;
		arst_n = 1'b0;
		samples_ch.valid = 1'b0;
		samples_ch.sample = '0;
		samples_ch.last = 1'b0;
		results_ch.ready = 1'b0;
		cycle_count = 0;
		error_count = 0;
		results_seen = 0;
		hold_left = 0;
		hold_started = 1'b0;
		stored_count = 0;
		top_value = '0;
		top_pos = 0;
		overflowed = 1'b0;

		// single-sample profiles: positive, negative, zero
		push_sample(5, 1, 0);
		push_sample(-3, 1, 0);
		push_sample(0, 1, 0);
		// extremes, peak on the left edge
		push_sample(8388607, 0, 0);
		push_sample(-8388608, 1, 0);
		// repeated minimum, first occurrence wins
		push_sample(-8388608, 0, 0);
		push_sample(-8388608, 0, 0);
		push_sample(-8388608, 1, 0);
		// positive hump
		push_sample(1, 0, 0);
		push_sample(2, 0, 0);
		push_sample(10, 0, 0);
		push_sample(9, 0, 0);
		push_sample(8, 0, 0);
		push_sample(1, 0, 0);
		push_sample(0, 1, 0);
		// negative peak inside the profile
		push_sample(-100, 0, 0);
		push_sample(-20, 0, 0);
		push_sample(-10, 0, 0);
		push_sample(-11, 0, 0);
		push_sample(-30, 1, 0);
		// peak on the right edge
		push_sample(3, 0, 0);
		push_sample(4, 0, 0);
		push_sample(7, 1, 0);

		random_count = 0;
		first = 1'b1;
		while (random_count < RANDOM_ITEMS) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : $urandom_range(2, 40);
			queue_profile(len, $urandom_range(0, 3), first || $urandom_range(0, 24) == 0);
			random_count += len;
			first = 1'b0;
		end
		// past capacity, including a dropped final sample
		queue_profile(PROFILE_DEPTH + 1, 0, 1);
		queue_profile(PROFILE_DEPTH + 6, 3, 0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_samples.size() != 0 || samples_ch.valid || expected_peaks.size() != 0)
			@(posedge clk);
		repeat (3 * PROFILE_DEPTH + 50) @(posedge clk);

		if (error_count == 0)
			$display("PASS peak_position_and_width_finder");
		else
			$display("FAIL peak_position_and_width_finder");
		$finish;
	end

endmodule

`default_nettype wire
